// ----- rtl/csa_pkg.sv -----
// ----------------------------------------------------------------------------
// csa_pkg
// Shared constants and types for the cone surface anchor pipeline.
// ----------------------------------------------------------------------------
package csa_pkg;

   localparam int NORM_W = 23;                    // normalized magnitude width
   localparam int R_FRAC = 8;                     // radius fraction bits
   localparam int SQ_W   = 2 * NORM_W + 1;        // x^2 + y^2
   localparam int RAD_W  = SQ_W + 2 * R_FRAC;     // radicand of the radius
   localparam int ROOT_W = (RAD_W + 1) / 2;       // radius r8
   localparam int DEN_W  = ROOT_W + 3;            // divisor

   typedef struct packed {
      logic              valid;
      logic              zero;
      logic              neg_x;
      logic              neg_y;
      logic              neg_z;
      logic [NORM_W-1:0] mag_x;
      logic [NORM_W-1:0] mag_y;
      logic [NORM_W-1:0] mag_z;
   } csa_vec_type;

endpackage

// ----- rtl/csa_norm.sv -----
// ----------------------------------------------------------------------------
// csa_norm
// Splits sign and magnitude, finds the leading one and scales all three
// magnitudes by one common shift. Three register stages.
// ----------------------------------------------------------------------------
module csa_norm #(
   parameter int IN_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic signed [IN_WIDTH-1:0] dir_x,
   input  logic signed [IN_WIDTH-1:0] dir_y,
   input  logic signed [IN_WIDTH-1:0] dir_z,
   output csa_pkg::csa_vec_type       vec
);

   localparam int PW   = $clog2(IN_WIDTH);
   localparam int SH_W = 6;
   localparam int EXT_W = IN_WIDTH + csa_pkg::NORM_W;
   localparam logic [SH_W-1:0] TOP = SH_W'(csa_pkg::NORM_W - 1);

   // stage 1
   logic                v1_ff;
   logic [2:0]          n1_ff;
   logic [IN_WIDTH-1:0] mx1_ff, my1_ff, mz1_ff, m1_ff;
   logic [IN_WIDTH-1:0] mx_in, my_in, mz_in, m_in;
   // stage 2
   logic                v2_ff, z2_ff;
   logic [2:0]          n2_ff;
   logic [IN_WIDTH-1:0] mx2_ff, my2_ff, mz2_ff;
   logic [PW-1:0]       p2_ff, p_in;
   // stage 3
   csa_pkg::csa_vec_type vec_ff, vec_in;
   logic [SH_W-1:0]      p_ext;

   function automatic logic [csa_pkg::NORM_W-1:0] scale(
      input logic [IN_WIDTH-1:0] mag,
      input logic                right,
      input logic [SH_W-1:0]     sh
   );
      logic [EXT_W-1:0] ext;
      ext = EXT_W'(mag);
      ext = right ? (ext >> sh) : (ext << sh);
      return ext[csa_pkg::NORM_W-1:0];
   endfunction

   always_comb begin
      mx_in = dir_x[IN_WIDTH-1] ? (~dir_x + 1'b1) : dir_x;
      my_in = dir_y[IN_WIDTH-1] ? (~dir_y + 1'b1) : dir_y;
      mz_in = dir_z[IN_WIDTH-1] ? (~dir_z + 1'b1) : dir_z;
      m_in  = mx_in;
      if (my_in > m_in) m_in = my_in;
      if (mz_in > m_in) m_in = mz_in;
   end

   always_comb begin
      p_in = '0;
      for (int i = 0; i < IN_WIDTH; i++) begin
         if (m1_ff[i]) p_in = PW'(i);
      end
   end

   always_comb begin
      p_ext        = SH_W'(p2_ff);
      vec_in.valid = v2_ff;
      vec_in.zero  = z2_ff;
      vec_in.neg_x = n2_ff[0];
      vec_in.neg_y = n2_ff[1];
      vec_in.neg_z = n2_ff[2];
      if (p_ext >= TOP) begin
         vec_in.mag_x = scale(mx2_ff, 1'b1, p_ext - TOP);
         vec_in.mag_y = scale(my2_ff, 1'b1, p_ext - TOP);
         vec_in.mag_z = scale(mz2_ff, 1'b1, p_ext - TOP);
      end else begin
         vec_in.mag_x = scale(mx2_ff, 1'b0, TOP - p_ext);
         vec_in.mag_y = scale(my2_ff, 1'b0, TOP - p_ext);
         vec_in.mag_z = scale(mz2_ff, 1'b0, TOP - p_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         vec_ff.valid <= 1'b0;
      end else if (en) begin
         v1_ff        <= in_valid;
         v2_ff        <= v1_ff;
         vec_ff.valid <= vec_in.valid;
      end
      if (en) begin
         n1_ff  <= {dir_z[IN_WIDTH-1], dir_y[IN_WIDTH-1], dir_x[IN_WIDTH-1]};
         mx1_ff <= mx_in;
         my1_ff <= my_in;
         mz1_ff <= mz_in;
         m1_ff  <= m_in;
         n2_ff  <= n1_ff;
         mx2_ff <= mx1_ff;
         my2_ff <= my1_ff;
         mz2_ff <= mz1_ff;
         p2_ff  <= p_in;
         z2_ff  <= (m1_ff == '0);
         vec_ff.zero  <= vec_in.zero;
         vec_ff.neg_x <= vec_in.neg_x;
         vec_ff.neg_y <= vec_in.neg_y;
         vec_ff.neg_z <= vec_in.neg_z;
         vec_ff.mag_x <= vec_in.mag_x;
         vec_ff.mag_y <= vec_in.mag_y;
         vec_ff.mag_z <= vec_in.mag_z;
      end
   end

   assign vec = vec_ff;

endmodule

// ----- rtl/csa_sqrt.sv -----
// ----------------------------------------------------------------------------
// csa_sqrt
// Pipelined restoring integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module csa_sqrt (
   input  logic                       clock,
   input  logic                       en,
   input  logic [csa_pkg::RAD_W-1:0]  rad,
   output logic [csa_pkg::ROOT_W-1:0] root
);

   localparam int N  = csa_pkg::ROOT_W;
   localparam int TW = csa_pkg::RAD_W + 2;

   logic [TW-1:0] rem_ff  [N];
   logic [TW-1:0] root_ff [N];

   for (genvar g = 0; g < N; g++) begin : g_stage
      localparam int B = N - 1 - g;
      logic [TW-1:0] rem_src, root_src, trial;
      if (g == 0) begin : g_first
         assign rem_src  = TW'(rad);
         assign root_src = '0;
      end else begin : g_next
         assign rem_src  = rem_ff[g-1];
         assign root_src = root_ff[g-1];
      end
      assign trial = (root_src << (B + 1)) + (TW'(1) << (2 * B));
      always_ff @(posedge clock) begin
         if (en) begin
            if (rem_src >= trial) begin
               rem_ff[g]  <= rem_src - trial;
               root_ff[g] <= root_src | (TW'(1) << B);
            end else begin
               rem_ff[g]  <= rem_src;
               root_ff[g] <= root_src;
            end
         end
      end
   end

   assign root = root_ff[N-1][N-1:0];

endmodule

// ----- rtl/csa_div.sv -----
// ----------------------------------------------------------------------------
// csa_div
// Pipelined restoring divider with round-to-nearest: one quotient bit per
// stage after a stage that forms the rounded numerator.
// ----------------------------------------------------------------------------
module csa_div #(
   parameter int FRAC_BITS = 14
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic [csa_pkg::NORM_W-1:0]  mag,
   input  logic [csa_pkg::DEN_W-1:0]   den,
   output logic [FRAC_BITS:0]          quo
);

   localparam int QW = FRAC_BITS + 2;
   localparam int CW = csa_pkg::DEN_W + QW + 1;
   localparam int SH = FRAC_BITS + csa_pkg::R_FRAC;

   logic [CW-1:0]                rem_ff [QW+1];
   logic [csa_pkg::DEN_W-1:0]    den_ff [QW+1];
   logic [QW-1:0]                quo_ff [QW+1];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= (CW'(mag) << SH) + CW'(den >> 1);
         den_ff[0] <= den;
         quo_ff[0] <= '0;
      end
   end

   for (genvar g = 1; g <= QW; g++) begin : g_stage
      localparam int K = QW - g;
      logic [CW-1:0] trial;
      assign trial = CW'(den_ff[g-1]) << K;
      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[g] <= den_ff[g-1];
            if (rem_ff[g-1] >= trial) begin
               rem_ff[g] <= rem_ff[g-1] - trial;
               quo_ff[g] <= quo_ff[g-1] | (QW'(1) << K);
            end else begin
               rem_ff[g] <= rem_ff[g-1];
               quo_ff[g] <= quo_ff[g-1];
            end
         end
      end
   end

   assign quo = quo_ff[QW][FRAC_BITS:0];

endmodule

// ----- rtl/cone_surface_anchor_top.sv -----
// ----------------------------------------------------------------------------
// cone_surface_anchor_top
// The root and quotient pipelines resolve one bit per stage. Throughput: one
// word per cycle; the whole pipe holds while an output word is stalled.
// Synchronous active-high reset clears valid bits and swap_ff.
// ----------------------------------------------------------------------------
module cone_surface_anchor_top #(
   parameter int FRAC_BITS = 14,
   parameter int IN_WIDTH  = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [IN_WIDTH-1:0]  req_dir_x,
   input  logic signed [IN_WIDTH-1:0]  req_dir_y,
   input  logic signed [IN_WIDTH-1:0]  req_dir_z,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [FRAC_BITS:0]   rsp_anchor_x,
   output logic signed [FRAC_BITS:0]   rsp_anchor_y,
   output logic signed [FRAC_BITS:0]   rsp_anchor_z,
   input  logic                        csr_we,
   input  logic                        csr_wdata
);

   localparam int NW   = csa_pkg::NORM_W;
   localparam int SQD  = csa_pkg::ROOT_W;
   localparam int DVD  = FRAC_BITS + 3;
   localparam int OW   = FRAC_BITS + 1;

   logic en;
   logic swap_ff;
   logic rsp_valid_ff;
   logic [OW-1:0] ax_ff, ay_ff, az_ff;

   csa_pkg::csa_vec_type v3;
   csa_pkg::csa_vec_type v4_ff, v5_ff, v6_ff;
   logic [2*NW-1:0] sx_ff, sy_ff, sz_ff;
   logic [csa_pkg::SQ_W-1:0] s_sum;
   logic [csa_pkg::RAD_W-1:0] rad_ff;
   logic cap5_ff, cap6_ff;
   csa_pkg::csa_vec_type sq_dly_ff [SQD];
   logic                 cap_dly_ff [SQD];
   logic [csa_pkg::ROOT_W-1:0] root;
   logic [csa_pkg::DEN_W-1:0]  den_in, den_ff, zden, rden;
   csa_pkg::csa_vec_type dv_dly_ff [DVD];
   logic [OW-1:0] qx, qy, qz;
   logic [OW-1:0] ox_in, oy_in, oz_in;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         swap_ff <= 1'b0;
      end else if (csr_we) begin
         swap_ff <= csr_wdata;
      end
   end

   csa_norm #(.IN_WIDTH(IN_WIDTH)) u_norm (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .dir_x    (req_dir_x),
      .dir_y    (req_dir_y),
      .dir_z    (req_dir_z),
      .vec      (v3)
   );

   // squares, then sum and cap test
   assign s_sum = csa_pkg::SQ_W'(sx_ff) + csa_pkg::SQ_W'(sy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff.valid <= 1'b0;
         v5_ff.valid <= 1'b0;
      end else if (en) begin
         v4_ff.valid <= v3.valid;
         v5_ff.valid <= v4_ff.valid;
      end
      if (en) begin
         v4_ff.zero  <= v3.zero;
         v4_ff.neg_x <= v3.neg_x;
         v4_ff.neg_y <= v3.neg_y;
         v4_ff.neg_z <= v3.neg_z;
         v4_ff.mag_x <= v3.mag_x;
         v4_ff.mag_y <= v3.mag_y;
         v4_ff.mag_z <= v3.mag_z;
         sx_ff <= v3.mag_x * v3.mag_x;
         sy_ff <= v3.mag_y * v3.mag_y;
         sz_ff <= v3.mag_z * v3.mag_z;
         v5_ff.zero  <= v4_ff.zero;
         v5_ff.neg_x <= v4_ff.neg_x;
         v5_ff.neg_y <= v4_ff.neg_y;
         v5_ff.neg_z <= v4_ff.neg_z;
         v5_ff.mag_x <= v4_ff.mag_x;
         v5_ff.mag_y <= v4_ff.mag_y;
         v5_ff.mag_z <= v4_ff.mag_z;
         rad_ff  <= {s_sum, {(2 * csa_pkg::R_FRAC){1'b0}}};
         cap5_ff <= v4_ff.neg_z && (v4_ff.mag_z != '0) &&
                    (s_sum < csa_pkg::SQ_W'(sz_ff));
      end
   end

   csa_sqrt u_sqrt (
      .clock (clock),
      .en    (en),
      .rad   (rad_ff),
      .root  (root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SQD; i++) sq_dly_ff[i].valid <= 1'b0;
      end else if (en) begin
         sq_dly_ff[0].valid <= v5_ff.valid;
         for (int i = 1; i < SQD; i++) sq_dly_ff[i].valid <= sq_dly_ff[i-1].valid;
      end
      if (en) begin
         sq_dly_ff[0].zero  <= v5_ff.zero;
         sq_dly_ff[0].neg_x <= v5_ff.neg_x;
         sq_dly_ff[0].neg_y <= v5_ff.neg_y;
         sq_dly_ff[0].neg_z <= v5_ff.neg_z;
         sq_dly_ff[0].mag_x <= v5_ff.mag_x;
         sq_dly_ff[0].mag_y <= v5_ff.mag_y;
         sq_dly_ff[0].mag_z <= v5_ff.mag_z;
         cap_dly_ff[0]      <= cap5_ff;
         for (int i = 1; i < SQD; i++) begin
            sq_dly_ff[i].zero  <= sq_dly_ff[i-1].zero;
            sq_dly_ff[i].neg_x <= sq_dly_ff[i-1].neg_x;
            sq_dly_ff[i].neg_y <= sq_dly_ff[i-1].neg_y;
            sq_dly_ff[i].neg_z <= sq_dly_ff[i-1].neg_z;
            sq_dly_ff[i].mag_x <= sq_dly_ff[i-1].mag_x;
            sq_dly_ff[i].mag_y <= sq_dly_ff[i-1].mag_y;
            sq_dly_ff[i].mag_z <= sq_dly_ff[i-1].mag_z;
            cap_dly_ff[i]      <= cap_dly_ff[i-1];
         end
      end
   end

   // divisor: cap uses 2|z|, side uses 4r +/- 2z (units 2^-8)
   always_comb begin
      zden = csa_pkg::DEN_W'(sq_dly_ff[SQD-1].mag_z) << (csa_pkg::R_FRAC + 1);
      rden = csa_pkg::DEN_W'(root) << 2;
      if (cap_dly_ff[SQD-1]) begin
         den_in = zden;
      end else if (sq_dly_ff[SQD-1].neg_z) begin
         den_in = rden - zden;
      end else begin
         den_in = rden + zden;
      end
      if (den_in == '0) den_in = csa_pkg::DEN_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff.valid <= 1'b0;
      end else if (en) begin
         v6_ff.valid <= sq_dly_ff[SQD-1].valid;
      end
      if (en) begin
         v6_ff.zero  <= sq_dly_ff[SQD-1].zero;
         v6_ff.neg_x <= sq_dly_ff[SQD-1].neg_x;
         v6_ff.neg_y <= sq_dly_ff[SQD-1].neg_y;
         v6_ff.neg_z <= sq_dly_ff[SQD-1].neg_z;
         v6_ff.mag_x <= sq_dly_ff[SQD-1].mag_x;
         v6_ff.mag_y <= sq_dly_ff[SQD-1].mag_y;
         v6_ff.mag_z <= sq_dly_ff[SQD-1].mag_z;
         den_ff      <= den_in;
         cap6_ff     <= cap_dly_ff[SQD-1];
      end
   end

   csa_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
      .clock (clock), .en (en), .mag (v6_ff.mag_x), .den (den_ff), .quo (qx)
   );
   csa_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
      .clock (clock), .en (en), .mag (v6_ff.mag_y), .den (den_ff), .quo (qy)
   );
   csa_div #(.FRAC_BITS(FRAC_BITS)) u_div_z (
      .clock (clock), .en (en), .mag (v6_ff.mag_z), .den (den_ff), .quo (qz)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DVD; i++) dv_dly_ff[i].valid <= 1'b0;
      end else if (en) begin
         dv_dly_ff[0].valid <= v6_ff.valid;
         for (int i = 1; i < DVD; i++) dv_dly_ff[i].valid <= dv_dly_ff[i-1].valid;
      end
      if (en) begin
         dv_dly_ff[0].zero  <= v6_ff.zero;
         dv_dly_ff[0].neg_x <= v6_ff.neg_x;
         dv_dly_ff[0].neg_y <= v6_ff.neg_y;
         dv_dly_ff[0].neg_z <= v6_ff.neg_z;
         dv_dly_ff[0].mag_x <= '0;
         dv_dly_ff[0].mag_y <= '0;
         dv_dly_ff[0].mag_z <= {{(NW-1){1'b0}}, cap6_ff};
         for (int i = 1; i < DVD; i++) begin
            dv_dly_ff[i].zero  <= dv_dly_ff[i-1].zero;
            dv_dly_ff[i].neg_x <= dv_dly_ff[i-1].neg_x;
            dv_dly_ff[i].neg_y <= dv_dly_ff[i-1].neg_y;
            dv_dly_ff[i].neg_z <= dv_dly_ff[i-1].neg_z;
            dv_dly_ff[i].mag_x <= dv_dly_ff[i-1].mag_x;
            dv_dly_ff[i].mag_y <= dv_dly_ff[i-1].mag_y;
            dv_dly_ff[i].mag_z <= dv_dly_ff[i-1].mag_z;
         end
      end
   end

   // sign, zero vector, y/z exchange
   always_comb begin
      ox_in = dv_dly_ff[DVD-1].neg_x ? (~qx + 1'b1) : qx;
      oy_in = dv_dly_ff[DVD-1].neg_y ? (~qy + 1'b1) : qy;
      oz_in = dv_dly_ff[DVD-1].neg_z ? (~qz + 1'b1) : qz;
      if (dv_dly_ff[DVD-1].zero) begin
         ox_in = '0;
         oy_in = '0;
         oz_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_dly_ff[DVD-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff <= ox_in;
         ay_ff <= swap_ff ? oz_in : oy_in;
         az_ff <= swap_ff ? oy_in : oz_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_anchor_x = ax_ff;
   assign rsp_anchor_y = ay_ff;
   assign rsp_anchor_z = az_ff;

endmodule
